### hw/rtl/assert_macros.svh
// Assertion helpers for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle.
`define PHT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");

// Implication in the next cycle.
`define PHT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

### hw/rtl/pht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pht_pkg;

	localparam logic [1:0] OP_PACKET = 2'd0;
	localparam logic [1:0] OP_TICK   = 2'd1;
	localparam logic [1:0] OP_QLOCAL = 2'd2;
	localparam logic [1:0] OP_QREM   = 2'd3;

	localparam logic [2:0] KIND_OUT     = 3'd0;
	localparam logic [2:0] KIND_IN      = 3'd1;
	localparam logic [2:0] KIND_IGNORED = 3'd2;
	localparam logic [2:0] KIND_SUMMARY = 3'd3;
	localparam logic [2:0] KIND_QUERY   = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	localparam logic [1:0] CFG_NET  = 2'd0;
	localparam logic [1:0] CFG_MASK = 2'd1;

	localparam logic [15:0] ETH_IPV4   = 16'h0800;
	localparam logic [7:0]  PROTO_TCP  = 8'd6;
	localparam logic [7:0]  PROTO_UDP  = 8'd17;
	localparam logic [7:0]  PROTO_ICMP = 8'd1;

	localparam logic [1:0] PSEL_TCP   = 2'd0;
	localparam logic [1:0] PSEL_UDP   = 2'd1;
	localparam logic [1:0] PSEL_ICMP  = 2'd2;
	localparam logic [1:0] PSEL_OTHER = 2'd3;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] bytes_out;
		logic [31:0] packets_out;
		logic [31:0] bytes_in;
		logic [31:0] packets_in;
		logic [31:0] tcp;
		logic [31:0] udp;
		logic [31:0] icmp;
		logic [31:0] other;
	} entry_t;

	typedef struct packed {
		logic        load;
		logic        rd;
		logic        exec;
		logic        clr;
		logic [15:0] clr_idx;
	} ctl_cmd_t;

	typedef struct packed {
		logic is_tick;
	} dp_sts_t;

	typedef struct packed {
		logic found;
		logic full;
	} tbl_sts_t;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage
`default_nettype wire

### hw/rtl/per_host_traffic_counter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: an accepted word passes the three-stage bucket index, then the row read and the
// row update; done is registered together with the update.
// A new word is accepted only while idle; a tick adds a clear pass over
// max(REMOTE_BUCKETS, LOCAL_BUCKETS) bucket rows, one bucket row per cycle.
// Reset: busy for the same clear pass after arst_n releases; config and totals reset to 0.
// The receiver cannot stall: done is high for exactly one cycle per word.
module per_host_traffic_counter_core #(
	parameter int REMOTE_BUCKETS = 2048,
	parameter int LOCAL_BUCKETS = 256,
	parameter int BUCKET_WAYS = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic [1:0]  opcode,
	input  wire logic [15:0] eth_type,
	input  wire logic [7:0]  ip_protocol,
	input  wire logic [31:0] source_address,
	input  wire logic [31:0] destination_address,
	input  wire logic [15:0] total_length,
	input  wire logic [31:0] host_address,
	output logic             done,
	output logic [2:0]       kind,
	output logic [1:0]       status,
	output logic [31:0]      total_bytes,
	output logic [31:0]      total_packets,
	output logic [31:0]      bytes_out,
	output logic [31:0]      packets_out,
	output logic [31:0]      bytes_in,
	output logic [31:0]      packets_in,
	output logic [31:0]      tcp_count,
	output logic [31:0]      udp_count,
	output logic [31:0]      icmp_count,
	output logic [31:0]      other_count
);

	localparam int CLR_N = (REMOTE_BUCKETS > LOCAL_BUCKETS) ? REMOTE_BUCKETS : LOCAL_BUCKETS;

	pht_pkg::ctl_cmd_t cmd;
	pht_pkg::dp_sts_t  sts;

	assign cfg_ready = 1'b1;

	pht_ctrl #(.CLR_N(CLR_N)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts), .busy(busy), .cmd(cmd)
	);

	pht_datapath #(
		.REMOTE_BUCKETS(REMOTE_BUCKETS), .LOCAL_BUCKETS(LOCAL_BUCKETS),
		.BUCKET_WAYS(BUCKET_WAYS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.opcode(opcode), .eth_type(eth_type), .ip_protocol(ip_protocol),
		.source_address(source_address), .destination_address(destination_address),
		.total_length(total_length), .host_address(host_address),
		.done(done), .kind(kind), .status(status),
		.total_bytes(total_bytes), .total_packets(total_packets),
		.bytes_out(bytes_out), .packets_out(packets_out),
		.bytes_in(bytes_in), .packets_in(packets_in),
		.tcp_count(tcp_count), .udp_count(udp_count),
		.icmp_count(icmp_count), .other_count(other_count)
	);

endmodule
`default_nettype wire

### hw/rtl/pht_table.sv
`timescale 1ns / 1ps
`default_nettype none
module pht_table #(
	parameter int BUCKETS = 256,
	parameter int WAYS = 4
) (
	input  wire logic              clk,
	input  wire pht_pkg::ctl_cmd_t cmd,
	input  wire logic              upd,
	input  wire logic [31:0]       key,
	input  wire logic              inbound,
	input  wire logic [15:0]       len,
	input  wire logic [1:0]        psel,
	output pht_pkg::tbl_sts_t      sts,
	output pht_pkg::entry_t        hit_ent
);

	localparam int IW = $clog2(BUCKETS);
	localparam int K = $clog2(BUCKETS);
	localparam longint MULT_L = ((64'd1 << (32 + K)) + longint'(BUCKETS) - 1) / longint'(BUCKETS);
	localparam logic [32:0] MULT = 33'(MULT_L);
	localparam logic [32:0] BKT = 33'(BUCKETS);

	typedef struct packed {
		logic [WAYS-1:0]                  vld;
		pht_pkg::entry_t [WAYS-1:0]       ent;
	} row_t;

	row_t mem [BUCKETS];

	logic [64:0]   prod_s1;
	logic [31:0]   qb_s2;
	logic [IW-1:0] idx_s3;
	row_t          row_q;

	logic [31:0]     quo;
	logic [32:0]     rem;
	logic [WAYS-1:0] hit, hit_oh, free_oh, sel_oh;
	pht_pkg::entry_t cur, nxt;
	row_t            new_row;
	logic            found, has_free;

	assign quo = 32'(prod_s1 >> (32 + K));
	assign rem = {1'b0, key} - {1'b0, qb_s2};

	always_ff @(posedge clk) begin
		prod_s1 <= 65'(key) * 65'(MULT);
		qb_s2   <= 32'(64'(quo) * 64'(BUCKETS));
		idx_s3  <= (rem >= BKT) ? IW'(rem - BKT) : IW'(rem);
	end

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			hit[w] = row_q.vld[w] && (row_q.ent[w].key == key);
		end
		hit_oh   = hit & (~hit + WAYS'(1));
		free_oh  = ~row_q.vld & (row_q.vld + WAYS'(1));
		found    = |hit;
		has_free = ~&row_q.vld;
		sel_oh   = found ? hit_oh : free_oh;
		hit_ent  = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (hit_oh[w]) begin
				hit_ent = hit_ent | row_q.ent[w];
			end
		end
		if (found) begin
			cur = hit_ent;
		end else begin
			cur = '0;
			cur.key = key;
		end
		nxt = cur;
		if (inbound) begin
			nxt.bytes_in   = pht_pkg::sat_add(cur.bytes_in, {16'd0, len});
			nxt.packets_in = pht_pkg::sat_add(cur.packets_in, 32'd1);
		end else begin
			nxt.bytes_out   = pht_pkg::sat_add(cur.bytes_out, {16'd0, len});
			nxt.packets_out = pht_pkg::sat_add(cur.packets_out, 32'd1);
		end
		case (psel)
			pht_pkg::PSEL_TCP: nxt.tcp = pht_pkg::sat_add(cur.tcp, 32'd1);
			pht_pkg::PSEL_UDP: nxt.udp = pht_pkg::sat_add(cur.udp, 32'd1);
			pht_pkg::PSEL_ICMP: nxt.icmp = pht_pkg::sat_add(cur.icmp, 32'd1);
			default: nxt.other = pht_pkg::sat_add(cur.other, 32'd1);
		endcase
		new_row = row_q;
		for (int w = 0; w < WAYS; w++) begin
			if (sel_oh[w]) begin
				new_row.vld[w] = 1'b1;
				new_row.ent[w] = nxt;
			end
		end
		sts.found = found;
		sts.full  = !found && !has_free;
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			if ({1'b0, cmd.clr_idx} < 17'(BUCKETS)) begin
				mem[cmd.clr_idx[IW-1:0]] <= '0;
			end
		end else if (upd && (found || has_free)) begin
			mem[idx_s3] <= new_row;
		end
		if (cmd.rd) begin
			row_q <= mem[idx_s3];
		end
	end

endmodule
`default_nettype wire

### hw/rtl/pht_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module pht_ctrl #(
	parameter int CLR_N = 2048
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire pht_pkg::dp_sts_t sts,
	output logic                  busy,
	output pht_pkg::ctl_cmd_t     cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_P1   = 3'd1;
	localparam logic [2:0] S_P2   = 3'd2;
	localparam logic [2:0] S_P3   = 3'd3;
	localparam logic [2:0] S_RD   = 3'd4;
	localparam logic [2:0] S_EX   = 3'd5;
	localparam logic [2:0] S_CLR  = 3'd6;

	logic [2:0]  state_q;
	logic [15:0] cnt_q;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd.load    = (state_q == S_IDLE) && start;
		cmd.rd      = (state_q == S_RD);
		cmd.exec    = (state_q == S_EX);
		cmd.clr     = (state_q == S_CLR);
		cmd.clr_idx = cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (start) state_q <= S_P1;
				S_P1: state_q <= S_P2;
				S_P2: state_q <= S_P3;
				S_P3: state_q <= S_RD;
				S_RD: state_q <= S_EX;
				S_EX: begin
					cnt_q   <= '0;
					state_q <= sts.is_tick ? S_CLR : S_IDLE;
				end
				S_CLR: begin
					cnt_q <= cnt_q + 16'd1;
					if (cnt_q == 16'(CLR_N - 1)) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### hw/rtl/pht_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module pht_datapath #(
	parameter int REMOTE_BUCKETS = 2048,
	parameter int LOCAL_BUCKETS = 256,
	parameter int BUCKET_WAYS = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pht_pkg::ctl_cmd_t cmd,
	output pht_pkg::dp_sts_t       sts,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [31:0]       cfg_data,
	input  wire logic [1:0]        opcode,
	input  wire logic [15:0]       eth_type,
	input  wire logic [7:0]        ip_protocol,
	input  wire logic [31:0]       source_address,
	input  wire logic [31:0]       destination_address,
	input  wire logic [15:0]       total_length,
	input  wire logic [31:0]       host_address,
	output logic                   done,
	output logic [2:0]             kind,
	output logic [1:0]             status,
	output logic [31:0]            total_bytes,
	output logic [31:0]            total_packets,
	output logic [31:0]            bytes_out,
	output logic [31:0]            packets_out,
	output logic [31:0]            bytes_in,
	output logic [31:0]            packets_in,
	output logic [31:0]            tcp_count,
	output logic [31:0]            udp_count,
	output logic [31:0]            icmp_count,
	output logic [31:0]            other_count
);

	logic [31:0] net_q, mask_q, tot_b_q, tot_p_q;
	logic [1:0]  op_q;
	logic [15:0] et_q, len_q;
	logic [7:0]  pr_q;
	logic [31:0] src_q, dst_q, host_q;

	logic        src_loc, dst_loc, counted, inbound;
	logic [31:0] rkey, lkey, nb, np;
	logic [1:0]  psel;
	pht_pkg::tbl_sts_t r_sts, l_sts;
	pht_pkg::entry_t   r_ent, l_ent, q_ent;
	logic        q_found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			net_q  <= '0;
			mask_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == pht_pkg::CFG_NET) net_q <= cfg_data;
			if (cfg_index == pht_pkg::CFG_MASK) mask_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= opcode;
			et_q   <= eth_type;
			pr_q   <= ip_protocol;
			src_q  <= source_address;
			dst_q  <= destination_address;
			len_q  <= total_length;
			host_q <= host_address;
		end
	end

	always_comb begin
		src_loc = (src_q & mask_q) == net_q;
		dst_loc = (dst_q & mask_q) == net_q;
		counted = (op_q == pht_pkg::OP_PACKET) && (et_q == pht_pkg::ETH_IPV4)
			&& (src_loc != dst_loc);
		inbound = dst_loc;
		rkey = (op_q == pht_pkg::OP_QREM) ? host_q : (inbound ? src_q : dst_q);
		lkey = (op_q == pht_pkg::OP_QLOCAL) ? host_q : (inbound ? dst_q : src_q);
		case (pr_q)
			pht_pkg::PROTO_TCP: psel = pht_pkg::PSEL_TCP;
			pht_pkg::PROTO_UDP: psel = pht_pkg::PSEL_UDP;
			pht_pkg::PROTO_ICMP: psel = pht_pkg::PSEL_ICMP;
			default: psel = pht_pkg::PSEL_OTHER;
		endcase
		nb = pht_pkg::sat_add(tot_b_q, {16'd0, len_q});
		np = pht_pkg::sat_add(tot_p_q, 32'd1);
		sts.is_tick = (op_q == pht_pkg::OP_TICK);
		q_found = (op_q == pht_pkg::OP_QLOCAL) ? l_sts.found : r_sts.found;
		q_ent   = (op_q == pht_pkg::OP_QLOCAL) ? l_ent : r_ent;
	end

	pht_table #(.BUCKETS(REMOTE_BUCKETS), .WAYS(BUCKET_WAYS)) u_remote (
		.clk(clk), .cmd(cmd), .upd(cmd.exec && counted), .key(rkey),
		.inbound(inbound), .len(len_q), .psel(psel), .sts(r_sts), .hit_ent(r_ent)
	);

	pht_table #(.BUCKETS(LOCAL_BUCKETS), .WAYS(BUCKET_WAYS)) u_local (
		.clk(clk), .cmd(cmd), .upd(cmd.exec && counted), .key(lkey),
		.inbound(inbound), .len(len_q), .psel(psel), .sts(l_sts), .hit_ent(l_ent)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_b_q <= '0;
			tot_p_q <= '0;
			done    <= 1'b0;
		end else begin
			done <= cmd.exec;
			if (cmd.exec && counted) begin
				tot_b_q <= nb;
				tot_p_q <= np;
			end else if (cmd.exec && sts.is_tick) begin
				tot_b_q <= '0;
				tot_p_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			total_bytes   <= counted ? nb : tot_b_q;
			total_packets <= counted ? np : tot_p_q;
			bytes_out   <= '0;
			packets_out <= '0;
			bytes_in    <= '0;
			packets_in  <= '0;
			tcp_count   <= '0;
			udp_count   <= '0;
			icmp_count  <= '0;
			other_count <= '0;
			status      <= pht_pkg::ST_OK;
			case (op_q)
				pht_pkg::OP_PACKET: begin
					if (counted) begin
						kind <= inbound ? pht_pkg::KIND_IN : pht_pkg::KIND_OUT;
						if (r_sts.full || l_sts.full) status <= pht_pkg::ST_FULL;
					end else begin
						kind <= pht_pkg::KIND_IGNORED;
					end
				end
				pht_pkg::OP_TICK: kind <= pht_pkg::KIND_SUMMARY;
				default: begin
					kind <= pht_pkg::KIND_QUERY;
					if (q_found) begin
						bytes_out   <= q_ent.bytes_out;
						packets_out <= q_ent.packets_out;
						bytes_in    <= q_ent.bytes_in;
						packets_in  <= q_ent.packets_in;
						tcp_count   <= q_ent.tcp;
						udp_count   <= q_ent.udp;
						icmp_count  <= q_ent.icmp;
						other_count <= q_ent.other;
					end else begin
						status <= pht_pkg::ST_NOTFOUND;
					end
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### hw/rtl/pht_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pht_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [2:0]  kind,
	input wire logic [1:0]  status,
	input wire logic [31:0] bytes_out
);

	`PHT_ASSERT_NXT(a_accept_busy, start && !busy, busy)
	`PHT_ASSERT_NXT(a_done_pulse, done, !done)
	`PHT_ASSERT_IMP(a_noquery_zero, done && (kind != pht_pkg::KIND_QUERY), bytes_out == 32'd0)
	`PHT_ASSERT_IMP(a_ignored_ok, done && (kind == pht_pkg::KIND_IGNORED), status == pht_pkg::ST_OK)

endmodule

bind per_host_traffic_counter_core pht_checker u_pht_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.kind(kind), .status(status), .bytes_out(bytes_out)
);
`default_nettype wire
